// ===== sv/combination_to_digit_indices_unit_defines.svh =====
// Assertion helpers shared by the RTL; clocked on clock, disabled in reset.
`ifndef COMBINATION_TO_DIGIT_INDICES_UNIT_DEFINES_SVH
`define COMBINATION_TO_DIGIT_INDICES_UNIT_DEFINES_SVH

`ifndef SYNTH
`define C2D_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("%m: implication check failed");
`define C2D_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("%m: next-cycle check failed");
`else
`define C2D_ASSERT_IMP(label, cond, prop)
`define C2D_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ===== sv/c2d_pkg.sv =====
package c2d_pkg;

   localparam int unsigned COMB_W = 64;
   localparam int unsigned IDX_W  = 7;
   localparam int unsigned POS_W  = 3;
   localparam int unsigned CNT_W  = $clog2(COMB_W);

   localparam logic [IDX_W-1:0] BASE_RESET = IDX_W'(26);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LENGTH,
      ST_DIVIDE,
      ST_DIGIT,
      ST_LONG
   } state_type;

   typedef struct packed {
      logic [COMB_W-1:0] combination;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] char_index;
      logic [POS_W-1:0] position;
      logic             last;
      logic             too_long;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic len_step;
      logic div_start;
      logic div_step;
      logic next_digit;
      logic emit_digit;
      logic emit_long;
   } cmd_type;

   typedef struct packed {
      logic base_zero;
      logic rem_ge_pwr;
      logic len_at_max;
      logic div_last;
      logic last_digit;
      logic out_free;
   } status_type;

endpackage

// ===== sv/c2d_stream_if.sv =====
interface c2d_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/c2d_ctrl.sv =====
`include "combination_to_digit_indices_unit_defines.svh"

module c2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  c2d_pkg::status_type  status,
   output c2d_pkg::cmd_type     cmd
);

   c2d_pkg::state_type state_ff;
   c2d_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c2d_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         c2d_pkg::ST_IDLE: begin
            if (req_valid) state_in = c2d_pkg::ST_LENGTH;
         end
         c2d_pkg::ST_LENGTH: begin
            priority if (status.base_zero) begin
               state_in = c2d_pkg::ST_LONG;
            end else if (status.rem_ge_pwr) begin
               if (status.len_at_max) state_in = c2d_pkg::ST_LONG;
            end else begin
               state_in = c2d_pkg::ST_DIVIDE;
            end
         end
         c2d_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = c2d_pkg::ST_DIGIT;
         end
         c2d_pkg::ST_DIGIT: begin
            if (status.out_free) begin
               state_in = status.last_digit ? c2d_pkg::ST_IDLE : c2d_pkg::ST_DIVIDE;
            end
         end
         c2d_pkg::ST_LONG: begin
            if (status.out_free) state_in = c2d_pkg::ST_IDLE;
         end
         default: state_in = c2d_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         c2d_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         c2d_pkg::ST_LENGTH: begin
            if (!status.base_zero) begin
               if (status.rem_ge_pwr) begin
                  cmd.len_step = !status.len_at_max;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end
         end
         c2d_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         c2d_pkg::ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               // more characters to come: restart the divider on the quotient
               cmd.next_digit = !status.last_digit;
               cmd.div_start  = !status.last_digit;
            end
         end
         c2d_pkg::ST_LONG: begin
            cmd.emit_long = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `C2D_ASSERT_IMP(a_emit_when_free, cmd.emit_digit || cmd.emit_long, status.out_free)
   `C2D_ASSERT_NEXT(a_divide_holds, state_ff == c2d_pkg::ST_DIVIDE && !status.div_last, state_ff == c2d_pkg::ST_DIVIDE)
   `C2D_ASSERT_IMP(a_single_cmd, 1'b1, !(cmd.len_step && cmd.div_step) && !(cmd.load && cmd.div_step))

endmodule

// ===== sv/c2d_dpath.sv =====
`include "combination_to_digit_indices_unit_defines.svh"

module c2d_dpath #(
   parameter int unsigned MAX_LEN = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  c2d_pkg::cmd_type                cmd,
   output c2d_pkg::status_type             status,
   input  logic [c2d_pkg::COMB_W-1:0]      combination,
   input  logic                            csr_valid,
   input  logic [c2d_pkg::IDX_W-1:0]       csr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output c2d_pkg::rsp_payload_type        rsp_data
);

   localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
   localparam int unsigned CW = c2d_pkg::COMB_W;
   localparam int unsigned IW = c2d_pkg::IDX_W;

   logic [IW-1:0]                 base_ff;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [CW-1:0]                 pwr_ff, pwr_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [LEN_W-1:0]              pos_ff, pos_in;
   logic [IW-1:0]                 part_ff, part_in;
   logic [c2d_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   c2d_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic [CW+IW-1:0]              product;
   logic [IW:0]                   trial;
   logic [IW:0]                   trial_diff;
   logic                          div_ge;
   logic                          last_digit;

   assign product    = {{IW{1'b0}}, pwr_ff} * {{CW{1'b0}}, base_ff};
   // restoring division, one quotient bit per cycle shifted into rem_ff
   assign trial      = {part_ff, rem_ff[CW-1]};
   assign trial_diff = trial - {1'b0, base_ff};
   assign div_ge     = trial >= {1'b0, base_ff};
   assign last_digit = (pos_ff + LEN_W'(1)) == len_ff;

   always_comb begin
      rem_in  = rem_ff;
      pwr_in  = pwr_ff;
      len_in  = len_ff;
      pos_in  = pos_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         rem_in = combination;
         pwr_in = {{(CW-IW){1'b0}}, base_ff};
         len_in = LEN_W'(1);
         pos_in = '0;
      end else if (cmd.len_step) begin
         rem_in = rem_ff - pwr_ff;
         pwr_in = product[CW-1:0];
         len_in = len_ff + LEN_W'(1);
      end
      if (cmd.div_step) begin
         rem_in  = {rem_ff[CW-2:0], div_ge};
         part_in = div_ge ? trial_diff[IW-1:0] : trial[IW-1:0];
         cnt_in  = cnt_ff + c2d_pkg::CNT_W'(1);
      end
      if (cmd.div_start) begin
         part_in = '0;
         cnt_in  = '0;
      end
      if (cmd.next_digit) pos_in = pos_ff + LEN_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit_digit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.char_index  = part_ff;
         rsp_data_in.position    = c2d_pkg::POS_W'(pos_ff);
         rsp_data_in.last        = last_digit;
         rsp_data_in.too_long    = 1'b0;
      end else if (cmd.emit_long) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.char_index  = '0;
         rsp_data_in.position    = '0;
         rsp_data_in.last        = 1'b1;
         rsp_data_in.too_long    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= c2d_pkg::BASE_RESET;
         rsp_valid_ff <= 1'b0;
         len_ff       <= LEN_W'(1);
         pos_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_valid) base_ff <= csr_data;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      pwr_ff      <= pwr_in;
      part_ff     <= part_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.base_zero  = base_ff == '0;
   assign status.rem_ge_pwr = rem_ff >= pwr_ff;
   assign status.len_at_max = len_ff == LEN_MAX;
   assign status.div_last   = cnt_ff == '1;
   assign status.last_digit = last_digit;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `C2D_ASSERT_IMP(a_digit_below_base, rsp_valid_ff && !rsp_data_ff.too_long, rsp_data_ff.char_index < base_ff)
   `C2D_ASSERT_IMP(a_long_is_single, rsp_valid_ff && rsp_data_ff.too_long, rsp_data_ff.last && rsp_data_ff.position == '0)
   `C2D_ASSERT_IMP(a_len_bounded, 1'b1, len_ff <= LEN_MAX && pos_ff < len_ff)

endmodule

// ===== sv/combination_to_digit_indices_unit.sv =====
// Channel     Dir  Payload                                     Transfer
// req_stream  in   combination[63:0]                           valid && ready
// rsp_stream  out  char_index[6:0] position[2:0] last too_long valid && ready
// csr_write   in   alphabet_size[6:0]                          valid && ready (ready tied high)
//
// One combination at a time. Length search: the candidate length grows by one while the
// remainder is at least the current power of alphabet_size; then each character comes from
// a restoring division of the remainder by alphabet_size and is then emitted. A password too
// long for MAX_LEN, or alphabet_size zero, gives a single too_long result.
// Reset: synchronous, active high; alphabet_size returns to 26.
// A stalled rsp_stream holds the next character in the divider; the input is only
// taken again once the last result of the item sits in the output register.
module combination_to_digit_indices_unit #(
   parameter int unsigned MAX_LEN = 7
) (
   input  logic         clock,
   input  logic         reset,
   c2d_stream_if.sink   req_stream,
   c2d_stream_if.source rsp_stream,
   c2d_stream_if.sink   csr_write
);

   c2d_pkg::cmd_type    cmd;
   c2d_pkg::status_type status;
   logic                req_ready;

   assign req_stream.ready = req_ready;
   assign csr_write.ready  = 1'b1;

   c2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_stream.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   c2d_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .combination (req_stream.data.combination),
      .csr_valid   (csr_write.valid),
      .csr_data    (csr_write.data),
      .rsp_ready   (rsp_stream.ready),
      .rsp_valid   (rsp_stream.valid),
      .rsp_data    (rsp_stream.data)
   );

endmodule
